### sv/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// Shared widths, types and the pixel word passed between the line walker
// and the lane packer of the line rasterizer.
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS = 8;
  localparam int PIX_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int CNT_W      = 3;
  localparam int LANES      = 4;
  localparam int LANE_IDX_W = 2;
  localparam int ERR_W      = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [COLOR_W-1:0]      color_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [LANE_IDX_W-1:0]   lane_idx_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // one pixel from the walker, held until the packer takes it
  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
    color_t color;
  } lr_pix_t;

endpackage

### sv/lr_cmd_if.sv
// ---------------------------------------------------------------------------
// lr_cmd_if
// Line command channel: two endpoints and a pen colour, valid/ready.
// ---------------------------------------------------------------------------
interface lr_cmd_if;
  logic            valid;
  logic            ready;
  lr_pkg::pix_t    start_x;
  lr_pkg::pix_t    start_y;
  lr_pkg::pix_t    end_x;
  lr_pkg::pix_t    end_y;
  lr_pkg::color_t  pen_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

### sv/lr_grp_if.sv
// ---------------------------------------------------------------------------
// lr_grp_if
// Pixel group channel: up to four pixels, lane count, colour, last marker.
// ---------------------------------------------------------------------------
interface lr_grp_if;
  logic            valid;
  logic            ready;
  lr_pkg::pix_t    lane0_x;
  lr_pkg::pix_t    lane0_y;
  lr_pkg::pix_t    lane1_x;
  lr_pkg::pix_t    lane1_y;
  lr_pkg::pix_t    lane2_x;
  lr_pkg::pix_t    lane2_y;
  lr_pkg::pix_t    lane3_x;
  lr_pkg::pix_t    lane3_y;
  lr_pkg::cnt_t    pixel_count;
  lr_pkg::color_t  pixel_color;
  logic            last_group;

  modport source (output valid, lane0_x, lane0_y, lane1_x, lane1_y, lane2_x, lane2_y,
                  lane3_x, lane3_y, pixel_count, pixel_color, last_group, input ready);
  modport sink   (input valid, lane0_x, lane0_y, lane1_x, lane1_y, lane2_x, lane2_y,
                  lane3_x, lane3_y, pixel_count, pixel_color, last_group, output ready);
endinterface

### sv/lr_walker.sv
// ---------------------------------------------------------------------------
// lr_walker
// Bresenham sequencer: a setup state orders the endpoints, then a single
// error update unit steps the major axis one pixel per taken pixel.
// ---------------------------------------------------------------------------
module lr_walker (
  input  logic              clk,
  input  logic              rst_n,
  lr_cmd_if.sink            in_cmd,
  output lr_pkg::lr_pix_t   pix,
  input  logic              pix_take
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_WALK} state_t;

  state_t          state_r, state_nxt;
  lr_pkg::coord_t  ax_r, ay_r, bx_r, by_r;
  lr_pkg::color_t  color_r;
  logic            steep_r, steep_nxt;
  logic            down_r, down_nxt;
  lr_pkg::coord_t  maj_r, maj_nxt;
  lr_pkg::coord_t  end_r, end_nxt;
  lr_pkg::coord_t  mnr_r, mnr_nxt;
  lr_pkg::coord_t  dmaj_r, dmaj_nxt;
  lr_pkg::coord_t  dmin_r, dmin_nxt;
  lr_pkg::err_t    err_r, err_nxt;

  // setup terms
  logic [lr_pkg::COORD_BITS:0] dx_s, dy_s, ndx_s, ndy_s;
  lr_pkg::coord_t  adx, ady, m0, n0, m1, n1, sm_maj, sm_min, em_maj, em_min;
  lr_pkg::coord_t  dmaj_s, dmin_s;
  logic            steep_s, swap_s;
  lr_pkg::err_t    err_dec;

  logic accept;
  assign accept       = in_cmd.valid && in_cmd.ready;
  assign in_cmd.ready = (state_r == S_IDLE);

  always_comb begin
    dx_s    = {1'b0, bx_r} - {1'b0, ax_r};
    dy_s    = {1'b0, by_r} - {1'b0, ay_r};
    ndx_s   = -dx_s;
    ndy_s   = -dy_s;
    adx     = dx_s[lr_pkg::COORD_BITS] ? ndx_s[lr_pkg::COORD_BITS-1:0]
                                       : dx_s[lr_pkg::COORD_BITS-1:0];
    ady     = dy_s[lr_pkg::COORD_BITS] ? ndy_s[lr_pkg::COORD_BITS-1:0]
                                       : dy_s[lr_pkg::COORD_BITS-1:0];
    steep_s = ady > adx;
    m0      = steep_s ? ay_r : ax_r;
    n0      = steep_s ? ax_r : ay_r;
    m1      = steep_s ? by_r : bx_r;
    n1      = steep_s ? bx_r : by_r;
    swap_s  = m0 > m1;
    sm_maj  = swap_s ? m1 : m0;
    sm_min  = swap_s ? n1 : n0;
    em_maj  = swap_s ? m0 : m1;
    em_min  = swap_s ? n0 : n1;
    dmaj_s  = steep_s ? ady : adx;
    dmin_s  = steep_s ? adx : ady;
  end

  // shared error unit: subtract minor span, add back major span on borrow
  assign err_dec = err_r - lr_pkg::err_t'({2'b00, dmin_r});

  always_comb begin
    state_nxt = state_r;
    steep_nxt = steep_r;
    down_nxt  = down_r;
    maj_nxt   = maj_r;
    end_nxt   = end_r;
    mnr_nxt   = mnr_r;
    dmaj_nxt  = dmaj_r;
    dmin_nxt  = dmin_r;
    err_nxt   = err_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        steep_nxt = steep_s;
        down_nxt  = !(sm_min < em_min);
        maj_nxt   = sm_maj;
        end_nxt   = em_maj;
        mnr_nxt   = sm_min;
        dmaj_nxt  = dmaj_s;
        dmin_nxt  = dmin_s;
        err_nxt   = lr_pkg::err_t'({2'b00, dmaj_s >> 1});
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (pix_take) begin
          if (maj_r == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            maj_nxt = maj_r + lr_pkg::coord_t'(1);
            if (err_dec[lr_pkg::ERR_W-1]) begin
              mnr_nxt = down_r ? mnr_r - lr_pkg::coord_t'(1) : mnr_r + lr_pkg::coord_t'(1);
              err_nxt = err_dec + lr_pkg::err_t'({2'b00, dmaj_r});
            end else begin
              err_nxt = err_dec;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      ax_r    <= in_cmd.start_x[lr_pkg::COORD_BITS-1:0];
      ay_r    <= in_cmd.start_y[lr_pkg::COORD_BITS-1:0];
      bx_r    <= in_cmd.end_x[lr_pkg::COORD_BITS-1:0];
      by_r    <= in_cmd.end_y[lr_pkg::COORD_BITS-1:0];
      color_r <= in_cmd.pen_color;
    end
    steep_r <= steep_nxt;
    down_r  <= down_nxt;
    maj_r   <= maj_nxt;
    end_r   <= end_nxt;
    mnr_r   <= mnr_nxt;
    dmaj_r  <= dmaj_nxt;
    dmin_r  <= dmin_nxt;
    err_r   <= err_nxt;
  end

  always_comb begin
    pix.valid = (state_r == S_WALK);
    pix.last  = (maj_r == end_r);
    pix.x     = steep_r ? mnr_r : maj_r;
    pix.y     = steep_r ? maj_r : mnr_r;
    pix.color = color_r;
  end

endmodule

### sv/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer
// Integer Bresenham line generator emitting pixels four to a word.
//
// in_cmd takes one line command (two endpoints, pen colour) when the block
// is idle; ready stays low until the last pixel of the line is packed.
// out_grp carries up to four pixels in walk order with a lane count, the
// colour and a marker on the final word of the line. Unused lanes are 0.
// A command passes through a setup state that orders the endpoints, then
// the single error update unit steps the walk one pixel per taken pixel.
// The output word sits in a register: the walker keeps stepping while it
// waits and only halts when the next word is complete and the register is
// still held by a stalled receiver.
// Reset (rst_n low, synchronous) returns the walker to idle and drops
// out_grp.valid; any command in flight is lost.
// ---------------------------------------------------------------------------
module line_rasterizer (
  input  logic   clk,
  input  logic   rst_n,
  lr_cmd_if.sink   in_cmd,
  lr_grp_if.source out_grp
);

  lr_pkg::lr_pix_t   pix;
  logic              pix_take;
  logic              out_free, word_done;
  lr_pkg::lane_idx_t cnt_r;
  lr_pkg::coord_t    buf_x_r [lr_pkg::LANES];
  lr_pkg::coord_t    buf_y_r [lr_pkg::LANES];
  lr_pkg::coord_t    lane_x  [lr_pkg::LANES];
  lr_pkg::coord_t    lane_y  [lr_pkg::LANES];

  logic              out_valid_r;
  lr_pkg::pix_t      out_x_r [lr_pkg::LANES];
  lr_pkg::pix_t      out_y_r [lr_pkg::LANES];
  lr_pkg::cnt_t      out_cnt_r;
  lr_pkg::color_t    out_color_r;
  logic              out_last_r;

  lr_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (in_cmd),
    .pix      (pix),
    .pix_take (pix_take)
  );

  assign out_free  = !out_valid_r || out_grp.ready;
  assign word_done = pix.last || (cnt_r == lr_pkg::lane_idx_t'(lr_pkg::LANES - 1));
  assign pix_take  = pix.valid && (!word_done || out_free);

  // buffered lanes, the incoming pixel in the next lane, zeros beyond
  always_comb begin
    for (int i = 0; i < lr_pkg::LANES; i++) begin
      if (lr_pkg::CNT_W'(i) < lr_pkg::CNT_W'(cnt_r)) begin
        lane_x[i] = buf_x_r[i];
        lane_y[i] = buf_y_r[i];
      end else if (lr_pkg::CNT_W'(i) == lr_pkg::CNT_W'(cnt_r)) begin
        lane_x[i] = pix.x;
        lane_y[i] = pix.y;
      end else begin
        lane_x[i] = '0;
        lane_y[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pix_take) begin
        cnt_r <= word_done ? '0 : cnt_r + lr_pkg::lane_idx_t'(1);
      end
      if (pix_take && word_done) begin
        out_valid_r <= 1'b1;
      end else if (out_grp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pix_take && !word_done) begin
      for (int i = 0; i < lr_pkg::LANES; i++) begin
        if (lr_pkg::lane_idx_t'(i) == cnt_r) begin
          buf_x_r[i] <= pix.x;
          buf_y_r[i] <= pix.y;
        end
      end
    end
    if (pix_take && word_done) begin
      for (int i = 0; i < lr_pkg::LANES; i++) begin
        out_x_r[i] <= lr_pkg::pix_t'(lane_x[i]);
        out_y_r[i] <= lr_pkg::pix_t'(lane_y[i]);
      end
      out_cnt_r   <= lr_pkg::CNT_W'(cnt_r) + lr_pkg::cnt_t'(1);
      out_color_r <= pix.color;
      out_last_r  <= pix.last;
    end
  end

  assign out_grp.valid       = out_valid_r;
  assign out_grp.lane0_x     = out_x_r[0];
  assign out_grp.lane0_y     = out_y_r[0];
  assign out_grp.lane1_x     = out_x_r[1];
  assign out_grp.lane1_y     = out_y_r[1];
  assign out_grp.lane2_x     = out_x_r[2];
  assign out_grp.lane2_y     = out_y_r[2];
  assign out_grp.lane3_x     = out_x_r[3];
  assign out_grp.lane3_y     = out_y_r[3];
  assign out_grp.pixel_count = out_cnt_r;
  assign out_grp.pixel_color = out_color_r;
  assign out_grp.last_group  = out_last_r;

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for line_rasterizer: drives line commands on in_cmd,
// rebuilds the Bresenham walk in a scoreboard and checks every pixel word
// taken from out_grp, with random idling on both sides of the block.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    lr_pkg::pix_t   start_x;
    lr_pkg::pix_t   start_y;
    lr_pkg::pix_t   end_x;
    lr_pkg::pix_t   end_y;
    lr_pkg::color_t pen_color;
  } line_cmd_t;

  typedef struct packed {
    lr_pkg::pix_t [lr_pkg::LANES-1:0] lane_x;
    lr_pkg::pix_t [lr_pkg::LANES-1:0] lane_y;
    lr_pkg::cnt_t                     count;
    lr_pkg::color_t                   color;
    logic                             last;
  } pixel_word_t;

  class pixel_scoreboard;
    pixel_word_t expected_words[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function void flag(string what, int exp_v, int act_v);
      errors++;
      if (errors <= 10) begin
        $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
      end
    endfunction

    // walk the line and queue the pixel words it should produce
    function void note_command(line_cmd_t c);
      int          ax, ay, bx, by, t, dmaj, dmin, err, step, mnr, lane, cmask;
      bit          steep;
      pixel_word_t w;
      cmask = (1 << lr_pkg::COORD_BITS) - 1;
      ax = c.start_x & cmask;
      ay = c.start_y & cmask;
      bx = c.end_x & cmask;
      by = c.end_y & cmask;
      steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dmaj = bx - ax;
      dmin = (by > ay) ? by - ay : ay - by;
      err  = dmaj / 2;
      step = (ay < by) ? 1 : -1;
      mnr  = ay;
      lane = 0;
      w    = '0;
      for (int maj = ax; maj <= bx; maj++) begin
        if (lane == 0) begin
          w = '0;
          w.color = c.pen_color;
        end
        w.lane_x[lane] = lr_pkg::pix_t'(steep ? mnr : maj);
        w.lane_y[lane] = lr_pkg::pix_t'(steep ? maj : mnr);
        lane++;
        w.count = lr_pkg::cnt_t'(lane);
        if (maj == bx) w.last = 1'b1;
        if (lane == lr_pkg::LANES) begin
          expected_words.push_back(w);
          lane = 0;
        end
        err -= dmin;
        if (err < 0) begin
          mnr += step;
          err += dmaj;
        end
      end
      if (lane != 0) expected_words.push_back(w);
    endfunction

    function void check_word(pixel_word_t got);
      pixel_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: unexpected pixel word %h", got);
        return;
      end
      want = expected_words.pop_front();
      for (int i = 0; i < lr_pkg::LANES; i++) begin
        if (got.lane_x[i] !== want.lane_x[i])
          flag($sformatf("lane%0d_x", i), want.lane_x[i], got.lane_x[i]);
        if (got.lane_y[i] !== want.lane_y[i])
          flag($sformatf("lane%0d_y", i), want.lane_y[i], got.lane_y[i]);
      end
      if (got.count !== want.count) flag("pixel_count", want.count, got.count);
      if (got.color !== want.color) flag("pixel_color", want.color, got.color);
      if (got.last !== want.last) flag("last_group", want.last, got.last);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  lr_cmd_if cmd_if ();
  lr_grp_if grp_if ();

  pixel_scoreboard board = new();

  line_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_if),
    .out_grp(grp_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    grp_if.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_word_t w;
    if (rst_n && grp_if.valid && grp_if.ready) begin
      w.lane_x = {grp_if.lane3_x, grp_if.lane2_x, grp_if.lane1_x, grp_if.lane0_x};
      w.lane_y = {grp_if.lane3_y, grp_if.lane2_y, grp_if.lane1_y, grp_if.lane0_y};
      w.count  = grp_if.pixel_count;
      w.color  = grp_if.pixel_color;
      w.last   = grp_if.last_group;
      board.check_word(w);
    end
  end

  // valid is only touched at falling edges, once per edge
  task automatic send_line(line_cmd_t c);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.start_x   <= c.start_x;
    cmd_if.start_y   <= c.start_y;
    cmd_if.end_x     <= c.end_x;
    cmd_if.end_y     <= c.end_y;
    cmd_if.pen_color <= c.pen_color;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic send_coords(int sx, int sy, int ex, int ey, int color);
    line_cmd_t c;
    c.start_x   = lr_pkg::pix_t'(sx);
    c.start_y   = lr_pkg::pix_t'(sy);
    c.end_x     = lr_pkg::pix_t'(ex);
    c.end_y     = lr_pkg::pix_t'(ey);
    c.pen_color = lr_pkg::color_t'(color);
    send_line(c);
  endtask

  function automatic int near_coord(int base);
    int v;
    v = base + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  task automatic send_random_line();
    int sx, sy, kind, d, ex, ey;
    sx   = $urandom_range(255);
    sy   = $urandom_range(255);
    kind = $urandom_range(99);
    if (kind < 65) begin
      send_coords(sx, sy, near_coord(sx), near_coord(sy), $urandom_range(65535));
    end else if (kind < 85) begin
      send_coords(sx, sy, $urandom_range(255), $urandom_range(255), $urandom_range(65535));
    end else if (kind < 90) begin
      send_coords(sx, sy, sx, sy, $urandom_range(65535));
    end else if (kind < 95) begin
      // horizontal or vertical
      if (kind[0]) send_coords(sx, sy, near_coord(sx), sy, $urandom_range(65535));
      else send_coords(sx, sy, sx, near_coord(sy), $urandom_range(65535));
    end else begin
      // equal spans in a random direction
      d  = $urandom_range(40);
      ex = ((kind[0] && sx + d <= 255) || sx < d) ? sx + d : sx - d;
      ey = ((kind[1] && sy + d <= 255) || sy < d) ? sy + d : sy - d;
      send_coords(sx, sy, ex, ey, $urandom_range(65535));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    cmd_if.valid     = 1'b0;
    cmd_if.start_x   = '0;
    cmd_if.start_y   = '0;
    cmd_if.end_x     = '0;
    cmd_if.end_y     = '0;
    cmd_if.pen_color = '0;
    grp_if.ready     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 59;
    // single points, colour zero and full white
    send_coords(0, 0, 0, 0, 16'h0000);
    send_coords(255, 255, 255, 255, 16'hFFFF);
    // longest lines on both axes and both diagonals
    send_coords(0, 0, 255, 0, 16'hF800);
    send_coords(0, 255, 0, 0, 16'h07E0);
    send_coords(0, 0, 255, 255, 16'h001F);
    send_coords(255, 0, 0, 255, 16'hAAAA);
    // two to five pixels, every lane count
    send_coords(10, 10, 11, 10, 16'h5555);
    send_coords(10, 10, 12, 10, 16'h1234);
    send_coords(10, 10, 13, 10, 16'h8001);
    send_coords(10, 10, 14, 10, 16'h7FFE);
    // steep and shallow in every direction
    send_coords(20, 5, 3, 40, 16'hFFFF);
    send_coords(3, 40, 20, 5, 16'h0000);
    send_coords(100, 200, 7, 190, 16'hC0DE);
    send_coords(7, 190, 100, 201, 16'h0F0F);
    send_coords(0, 255, 255, 254, 16'hF0F0);
    send_coords(128, 0, 127, 255, 16'h3C3C);
    send_coords(50, 50, 60, 45, 16'hAAAA);
    send_coords(60, 45, 50, 50, 16'h5555);
    send_coords(200, 17, 203, 29, 16'h0001);
    send_coords(5, 5, 9, 9, 16'h8000);
    send_coords(9, 5, 5, 9, 16'h4321);

    for (int i = 0; i < 66; i++) send_random_line();
    send_idle_pct = 59;
    recv_idle_pct = 32;
    for (int i = 0; i < 66; i++) send_random_line();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 67; i++) send_random_line();
    @(negedge clk);
    cmd_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

endmodule
